// File: src/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the settable wall clock
// Character codes, place weights of the time digits and the command decode.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

  localparam int unsigned DayW   = 17;   // seconds of the day
  localparam int unsigned AccW   = 19;   // room for 99:99:99 before the range check
  localparam int unsigned DigW   = 4;
  localparam int unsigned NumDig = 6;
  localparam int unsigned PhaseW = 3;

  localparam logic [DayW-1:0] SecsPerDay = 17'd86400;
  localparam logic [DayW-1:0] LastSec    = 17'd86399;

  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChColon   = 8'h3A;  // ':'
  localparam logic [7:0] ChStop    = 8'h54;  // 'T'
  localparam logic [7:0] ChSet     = 8'h53;  // 'S'
  localparam logic [7:0] ChReset   = 8'h52;  // 'R'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;

  typedef enum logic {
    ALU_SUB,
    ALU_MAC
  } alu_op_t;

  typedef logic [NumDig-1:0][DigW-1:0] digits_t;

  // decoded command beat
  typedef struct packed {
    logic    is_stop;
    logic    is_reset;
    logic    is_set;   // prefix, command and text all good
    digits_t digits;   // hh mm ss, most significant first
  } cmd_info_t;

  // weight of each digit position in seconds: hour tens down to second ones
  function automatic logic [15:0] place_weight(input logic [PhaseW-1:0] idx);
    logic [15:0] w;
    case (idx)
      3'd0:    w = 16'd36000;
      3'd1:    w = 16'd3600;
      3'd2:    w = 16'd600;
      3'd3:    w = 16'd60;
      3'd4:    w = 16'd10;
      3'd5:    w = 16'd1;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/swc_alu.sv
// ----------------------------------------------------------------------------
// swc_alu: shared arithmetic unit
// Subtracts a place weight (digit extraction) or adds digit times weight
// (time loading); also reports whether the operand covers the weight.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_alu (
  input  wire swc_pkg::alu_op_t                op,
  input  wire logic [swc_pkg::AccW-1:0]       a,
  input  wire logic [swc_pkg::DigW-1:0]       digit,
  input  wire logic [swc_pkg::PhaseW-1:0]     widx,
  output logic      [swc_pkg::AccW-1:0]       result,
  output logic                                ge
);

  logic [15:0] weight;
  logic [swc_pkg::DigW-1:0] mult;
  logic [19:0] product;

  always_comb begin
    weight  = swc_pkg::place_weight(widx);
    mult    = (op == swc_pkg::ALU_SUB) ? 4'd1 : digit;
    product = mult * weight;
    ge      = ({1'b0, a} >= product);
    if (op == swc_pkg::ALU_SUB) begin
      result = a - product[swc_pkg::AccW-1:0];
    end else begin
      result = a + product[swc_pkg::AccW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/swc_cmd_chk.sv
// ----------------------------------------------------------------------------
// swc_cmd_chk: command text checker
// Decodes the command character and validates the hh:mm:ss text of a set.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_cmd_chk (
  input  wire logic [87:0]         text,
  output swc_pkg::cmd_info_t       info
);

  logic [10:0][7:0] ch;
  logic             prefix_ok;
  logic             digits_ok;
  logic             seps_ok;
  logic             end_ok;
  swc_pkg::digits_t dg;

  // digit characters sit at byte places 2,3,5,6,8,9
  localparam int DigPos [6] = '{2, 3, 5, 6, 8, 9};

  always_comb begin
    ch        = text;
    prefix_ok = (ch[0] == swc_pkg::ChPercent);
    seps_ok   = (ch[4] == swc_pkg::ChColon) && (ch[7] == swc_pkg::ChColon);
    end_ok    = (ch[10] == swc_pkg::ChSpace) || (ch[10] == swc_pkg::ChCr) ||
                (ch[10] == swc_pkg::ChLf);
    digits_ok = 1'b1;
    for (int i = 0; i < swc_pkg::NumDig; i++) begin
      digits_ok = digits_ok && (ch[DigPos[i]] >= swc_pkg::ChZero) &&
                  (ch[DigPos[i]] <= swc_pkg::ChNine);
      dg[i] = ch[DigPos[i]][3:0];
    end
    info.is_stop  = prefix_ok && (ch[1] == swc_pkg::ChStop);
    info.is_reset = prefix_ok && (ch[1] == swc_pkg::ChReset);
    info.is_set   = prefix_ok && (ch[1] == swc_pkg::ChSet) && seps_ok &&
                    digits_ok && end_ok;
    info.digits   = dg;
  end

endmodule

`default_nettype wire

// File: src/settable_wall_clock.sv
// ----------------------------------------------------------------------------
// settable_wall_clock: hh:mm:ss wall clock driven by ticks and commands
// Sequencer around one shared subtract / multiply-add unit.
// ----------------------------------------------------------------------------
// Input stream (s_*): one beat per tick or command. s_tuser = 0 is a
// one-second tick, 1 a command whose text sits in s_tdata.
// Output stream (m_*): one beat of six time digits per tick while the
// display is on; the digits show the time before the tick advances it.
// A tick with the display on walks the count through the shared unit, one
// compare-subtract per cycle against the place weights of all digits but
// the seconds ones, which is the remainder left over, before the result is
// registered. A tick with the display off, and 'T' or 'R', finish in IDLE;
// 'S' runs six multiply-add steps and then a range check.
// s_tready is low while an item is being worked on. A result waiting in the
// output register does not block new input; only the next result's load
// waits for the receiver to take the previous beat.
// Reset clears the count to midnight and turns the display off.
// ----------------------------------------------------------------------------
`default_nettype none

module settable_wall_clock (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // prefix, command, hour tens, hour ones, sep, min tens, min ones,
  // sep, sec tens, sec ones, end char (8 bits each, from bit 0 up)
  input  wire logic [87:0] s_tdata,
  // req_type
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // hour_tens[1:0], hour_ones[5:2], minute_tens[8:6], minute_ones[12:9],
  // sec_tens[15:13], sec_ones[19:16], zero pad [23:20]
  output logic [23:0]      m_tdata
);

  typedef enum logic [2:0] {
    IDLE,
    CONVERT,
    ACCUM,
    CHECK,
    EMIT
  } state_t;

  state_t                         state;
  logic [swc_pkg::DayW-1:0]       day_seconds;
  logic                           display_on;
  logic [swc_pkg::AccW-1:0]       acc;
  logic [swc_pkg::PhaseW-1:0]     phase;
  swc_pkg::digits_t               dig;

  swc_pkg::cmd_info_t             info;
  swc_pkg::alu_op_t               alu_op;
  logic [swc_pkg::AccW-1:0]       alu_res;
  logic                           alu_ge;
  logic                           in_beat;

  swc_cmd_chk u_chk (
    .text (s_tdata),
    .info (info)
  );

  assign alu_op = (state == ACCUM) ? swc_pkg::ALU_MAC : swc_pkg::ALU_SUB;

  swc_alu u_alu (
    .op     (alu_op),
    .a      (acc),
    .digit  (dig[phase]),
    .widx   (phase),
    .result (alu_res),
    .ge     (alu_ge)
  );

  assign s_tready = (state == IDLE);
  assign in_beat  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      day_seconds <= '0;
      display_on  <= 1'b0;
      m_tvalid    <= 1'b0;
      phase       <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_beat) begin
            if (s_tuser[0] == 1'b0) begin
              if (day_seconds == swc_pkg::LastSec) begin
                day_seconds <= '0;
              end else begin
                day_seconds <= day_seconds + 17'd1;
              end
              if (display_on) begin
                acc   <= {2'b00, day_seconds};
                phase <= '0;
                dig   <= '0;
                state <= CONVERT;
              end
            end else if (info.is_stop) begin
              display_on <= 1'b0;
            end else if (info.is_reset) begin
              day_seconds <= '0;
              display_on  <= 1'b1;
            end else if (info.is_set) begin
              acc   <= '0;
              phase <= '0;
              dig   <= info.digits;
              state <= ACCUM;
            end
          end
        end
        CONVERT: begin
          // peel off one weight per cycle; the remainder below ten is the last digit
          if (alu_ge) begin
            acc        <= alu_res;
            dig[phase] <= dig[phase] + 4'd1;
          end else if (phase == 3'd4) begin
            dig[5] <= acc[swc_pkg::DigW-1:0];
            state  <= EMIT;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ACCUM: begin
          acc <= alu_res;
          if (phase == 3'd5) begin
            state <= CHECK;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        CHECK: begin
          if (acc < {2'b00, swc_pkg::SecsPerDay}) begin
            day_seconds <= acc[swc_pkg::DayW-1:0];
            display_on  <= 1'b1;
          end
          state <= IDLE;
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, dig[5], dig[4][2:0], dig[3], dig[2][2:0],
                         dig[1], dig[0][1:0]};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
